### hw/rtl/fbvs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbvs_pkg
// Shared types and constants for the viewport scan-out block.
// ----------------------------------------------------------------------------
package fbvs_pkg;

  localparam int unsigned GRID_WIDTH_DEF    = 8;
  localparam int unsigned GRID_HEIGHT_DEF   = 8;
  localparam int unsigned MAX_VIEW_COLS_DEF = 8;
  localparam int unsigned MAX_VIEW_ROWS_DEF = 8;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 4;

  typedef enum logic [1:0] {
    FUNC_CLEAR   = 2'd0,
    FUNC_WR_XY   = 2'd1,
    FUNC_WR_FLAT = 2'd2,
    FUNC_DISPLAY = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_COL = 2'd0,
    CFG_ORIGIN_ROW = 2'd1,
    CFG_VIEW_COLS  = 2'd2,
    CFG_VIEW_ROWS  = 2'd3
  } cfg_idx_t;

  // store port control
  typedef struct packed {
    logic we;
    logic re;
  } store_ctl_t;

endpackage

### hw/rtl/fbvs_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbvs_in_if
// Input item channel: valid/ready with command payload.
// ----------------------------------------------------------------------------
interface fbvs_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [15:0] col;
  logic signed [15:0] row;
  logic signed [15:0] flat_pos;
  logic [7:0]         pixel_in;

  modport source (output valid, func, col, row, flat_pos, pixel_in, input ready);
  modport sink (input valid, func, col, row, flat_pos, pixel_in, output ready);
endinterface

### hw/rtl/fbvs_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbvs_out_if
// Result channel: valid/ready with scanned pixel payload.
// ----------------------------------------------------------------------------
interface fbvs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_out;
  logic       last_of_frame;

  modport source (output valid, pixel_out, last_of_frame, input ready);
  modport sink (input valid, pixel_out, last_of_frame, output ready);
endinterface

### hw/rtl/fbvs_addr_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbvs_addr_unit
// Shared address unit: flat index = y * GRID_WIDTH + x.
// ----------------------------------------------------------------------------
module fbvs_addr_unit #(
  parameter int unsigned GRID_WIDTH = fbvs_pkg::GRID_WIDTH_DEF,
  parameter int unsigned XW         = 3,
  parameter int unsigned YW         = 3,
  parameter int unsigned AW         = 6
) (
  input  logic [XW-1:0] x,
  input  logic [YW-1:0] y,
  output logic [AW-1:0] addr
);

  logic [17:0] sum;

  assign sum  = 18'(y) * 18'(GRID_WIDTH) + 18'(x);
  assign addr = sum[AW-1:0];

endmodule

### hw/rtl/fbvs_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbvs_store
// Byte-per-pixel frame store, single port, registered read data.
// ----------------------------------------------------------------------------
module fbvs_store #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic                   clk,
  input  fbvs_pkg::store_ctl_t   ctl,
  input  logic [AW-1:0]          addr,
  input  logic [7:0]             wdata,
  output logic [7:0]             rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.re) begin
      rdata <= mem[addr];
    end
  end

endmodule

### hw/rtl/framebuffer_viewport_scanout.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framebuffer_viewport_scanout
// Frame store with clear, coordinate/linear writes and wrapped viewport scan.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all GRID_WIDTH*GRID_HEIGHT
// entries (ready low, config writes still taken). Coordinate and linear
// writes are made in the accept cycle. A clear writes one store entry per
// cycle through the single store port. A display is accepted, then sets up
// the scan origin, subtracting one grid length per step to wrap an origin
// beyond the grid; then each result is a store read followed by a transfer,
// held while the output stalls. The single store port and the shared address
// unit set that pace. Item ready stays low until the scan ends. An empty
// viewport finishes in the accept cycle.
// ----------------------------------------------------------------------------
module framebuffer_viewport_scanout #(
  parameter int unsigned GRID_WIDTH    = fbvs_pkg::GRID_WIDTH_DEF,
  parameter int unsigned GRID_HEIGHT   = fbvs_pkg::GRID_HEIGHT_DEF,
  parameter int unsigned MAX_VIEW_COLS = fbvs_pkg::MAX_VIEW_COLS_DEF,
  parameter int unsigned MAX_VIEW_ROWS = fbvs_pkg::MAX_VIEW_ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [fbvs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fbvs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  fbvs_in_if.sink                         item,
  fbvs_out_if.source                      result
);

  localparam int unsigned DEPTH = GRID_WIDTH * GRID_HEIGHT;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
  localparam int unsigned RW    = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
  localparam int unsigned XW    = (CW > 3) ? CW : 3;
  localparam int unsigned YW    = (RW > 3) ? RW : 3;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_PREP  = 5'b00100,
    S_READ  = 5'b01000,
    S_SEND  = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [2:0] origin_col, origin_row;
  logic [3:0] view_cols, view_rows;
  logic [3:0] nc, nr;

  logic [AW-1:0] clr_addr;
  logic [XW-1:0] x;
  logic [YW-1:0] y, y0;
  logic [3:0]    i, j;

  logic [XW-1:0] au_x;
  logic [YW-1:0] au_y;
  logic [AW-1:0] au_addr;
  logic [AW-1:0] st_addr;
  logic [7:0]    st_wdata;
  logic [7:0]    st_rdata;
  fbvs_pkg::store_ctl_t st_ctl;

  logic          accept;
  logic          xy_ok, flat_ok;
  logic          x_big, y_big;
  logic          last;
  logic          view_empty;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_col <= '0;
      origin_row <= '0;
      view_cols  <= 4'd8;
      view_rows  <= 4'd8;
    end else if (cfg_we) begin
      case (fbvs_pkg::cfg_idx_t'(cfg_index))
        fbvs_pkg::CFG_ORIGIN_COL: origin_col <= cfg_wdata[2:0];
        fbvs_pkg::CFG_ORIGIN_ROW: origin_row <= cfg_wdata[2:0];
        fbvs_pkg::CFG_VIEW_COLS:  view_cols  <= cfg_wdata;
        fbvs_pkg::CFG_VIEW_ROWS:  view_rows  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign nc = (view_cols > 4'(MAX_VIEW_COLS)) ? 4'(MAX_VIEW_COLS) : view_cols;
  assign nr = (view_rows > 4'(MAX_VIEW_ROWS)) ? 4'(MAX_VIEW_ROWS) : view_rows;
  assign view_empty = (nc == 4'd0) || (nr == 4'd0);

  assign item.ready = (state == S_IDLE);
  assign accept     = item.valid && item.ready;

  assign xy_ok = !item.col[15] && !item.row[15] &&
                 ({1'b0, item.col} < 17'(GRID_WIDTH)) &&
                 ({1'b0, item.row} < 17'(GRID_HEIGHT));
  assign flat_ok = !item.flat_pos[15] && ({1'b0, item.flat_pos} < 17'(DEPTH));

  assign x_big = (10'(x)  >= 10'(GRID_WIDTH));
  assign y_big = (10'(y0) >= 10'(GRID_HEIGHT));
  assign last  = (i == nc - 4'd1) && (j == nr - 4'd1);

  // shared address unit: scan position or write coordinate
  always_comb begin
    if (state == S_READ) begin
      au_x = x;
      au_y = y;
    end else begin
      au_x = item.col[XW-1:0];
      au_y = item.row[YW-1:0];
    end
  end

  fbvs_addr_unit #(
    .GRID_WIDTH (GRID_WIDTH),
    .XW         (XW),
    .YW         (YW),
    .AW         (AW)
  ) u_addr (
    .x    (au_x),
    .y    (au_y),
    .addr (au_addr)
  );

  // store port
  always_comb begin
    st_ctl   = '0;
    st_addr  = au_addr;
    st_wdata = item.pixel_in;
    case (state)
      S_CLEAR: begin
        st_ctl.we = 1'b1;
        st_addr   = clr_addr;
        st_wdata  = '0;
      end
      S_IDLE: begin
        if (item.valid) begin
          case (fbvs_pkg::func_t'(item.func))
            fbvs_pkg::FUNC_WR_XY:   st_ctl.we = xy_ok;
            fbvs_pkg::FUNC_WR_FLAT: begin
              st_ctl.we = flat_ok;
              st_addr   = item.flat_pos[AW-1:0];
            end
            default: ;
          endcase
        end
      end
      S_READ:  st_ctl.re = 1'b1;
      default: ;
    endcase
  end

  fbvs_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .ctl   (st_ctl),
    .addr  (st_addr),
    .wdata (st_wdata),
    .rdata (st_rdata)
  );

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          case (fbvs_pkg::func_t'(item.func))
            fbvs_pkg::FUNC_CLEAR:   state_next = S_CLEAR;
            fbvs_pkg::FUNC_DISPLAY: state_next = view_empty ? S_IDLE : S_PREP;
            default:                state_next = S_IDLE;
          endcase
        end
      end
      S_PREP: begin
        if (!x_big && !y_big) begin
          state_next = S_READ;
        end
      end
      S_READ: state_next = S_SEND;
      S_SEND: begin
        if (result.ready) begin
          state_next = last ? S_IDLE : S_READ;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      x        <= '0;
      y        <= '0;
      y0       <= '0;
      i        <= '0;
      j        <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= (clr_addr == AW'(DEPTH - 1)) ? '0 : clr_addr + AW'(1);
        end
        S_IDLE: begin
          clr_addr <= '0;
          if (accept) begin
            x  <= XW'(origin_col);
            y0 <= YW'(origin_row);
            i  <= '0;
            j  <= '0;
          end
        end
        S_PREP: begin
          // wrap origin into the grid by repeated subtraction
          if (x_big) begin
            x <= XW'(10'(x) - 10'(GRID_WIDTH));
          end
          if (y_big) begin
            y0 <= YW'(10'(y0) - 10'(GRID_HEIGHT));
          end else begin
            y <= y0;
          end
        end
        S_SEND: begin
          if (result.ready && !last) begin
            if (j == nr - 4'd1) begin
              j <= '0;
              i <= i + 4'd1;
              y <= y0;
              x <= (x == XW'(GRID_WIDTH - 1)) ? '0 : x + XW'(1);
            end else begin
              j <= j + 4'd1;
              y <= (y == YW'(GRID_HEIGHT - 1)) ? '0 : y + YW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign result.valid         = (state == S_SEND);
  assign result.pixel_out     = st_rdata;
  assign result.last_of_frame = last;

  // checks
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ || state == S_SEND) |-> !st_ctl.we)
    else $error("store write during scan");

  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR && clr_addr == AW'(DEPTH - 1)) |=> (state == S_IDLE))
    else $error("clear pass did not end");

  a_scan_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEND) |-> (i < nc && j < nr))
    else $error("scan counter out of viewport");

  a_pos_wrapped: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (10'(x) < 10'(GRID_WIDTH) && 10'(y) < 10'(GRID_HEIGHT)))
    else $error("scan position outside grid");

endmodule
